@@ rtl/dsp_image_validator_unit_defines.svh @@
`ifndef DSP_IMAGE_VALIDATOR_UNIT_DEFINES_SVH
`define DSP_IMAGE_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication, skipped while rst is high
`define DSPIV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dspiv implication check failed");

// next-cycle implication, skipped while rst is high
`define DSPIV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dspiv next-cycle check failed");

`endif

@@ rtl/dspiv_pkg.sv @@
package dspiv_pkg;

   localparam int ADDRESS_ENTRIES = 64;
   localparam int ADDR_IDX_W      = $clog2(ADDRESS_ENTRIES);
   localparam int WORD_W          = 16;
   localparam int INDEX_W         = 7;
   localparam int BYTES_W         = 18;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 18;

   localparam logic [INDEX_W:0]   STEP_COUNT     = 8'd128;
   localparam logic [BYTES_W-1:0] MAX_WORK_BYTES = 18'd131072;
   localparam logic [BYTES_W-1:0] RING_BASE      = 18'd16384;

   localparam logic [WORD_W-1:0] COEF_RESERVED  = 16'h0007;
   localparam logic [WORD_W-1:0] MEM_TABLE      = 16'h8000;
   localparam logic [WORD_W-1:0] MEM_WRITE      = 16'h4000;
   localparam logic [WORD_W-1:0] MEM_READ       = 16'h2000;
   localparam logic [WORD_W-1:0] IN_ADDR_MASK   = 16'h1f80;
   localparam logic [WORD_W-1:0] CTL_NO_FLOAT   = 16'h8000;
   localparam logic [WORD_W-1:0] CTL_INDEX_MASK = 16'h7e00;
   localparam logic [WORD_W-1:0] CTL_ADDR_REG   = 16'h0100;
   localparam logic [WORD_W-1:0] CTL_NEXT       = 16'h0080;
   localparam logic [WORD_W-1:0] CTL_RESERVED   = 16'h007f;
   localparam logic [5:0]        LAST_INPUT     = 6'h31;
   localparam logic [WORD_W-1:0] ADDR_REG_SPAN  = 16'h0fff;
   localparam logic [WORD_W-1:0] SPAN_LIMIT     = 16'hf000;
   localparam logic [WORD_W-1:0] WORD_ADDR_MAX  = 16'hffff;

   typedef enum logic [1:0] {
      CMD_COEF = 2'd0,
      CMD_ADDR = 2'd1,
      CMD_STEP = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RING_SIZE  = 1'd0,
      CSR_INIT_BYTES = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [INDEX_W-1:0] index;
      logic [WORD_W-1:0]  word_zero;
      logic [WORD_W-1:0]  word_one;
      logic [WORD_W-1:0]  word_two;
      logic [WORD_W-1:0]  word_three;
      logic               final_item;
   } req_beat_type;

   typedef struct packed {
      logic               fail;
      logic               nonzero;
      logic               access;
      logic [BYTES_W-1:0] bytes;
   } chk_result_type;

endpackage

@@ rtl/dspiv_if.sv @@
interface dspiv_req_if import dspiv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [INDEX_W-1:0] index;
   logic [WORD_W-1:0]  word_zero;
   logic [WORD_W-1:0]  word_one;
   logic [WORD_W-1:0]  word_two;
   logic [WORD_W-1:0]  word_three;
   logic               final_item;

   modport source (output valid, command, index, word_zero, word_one, word_two,
                   word_three, final_item, input ready);
   modport sink (input valid, command, index, word_zero, word_one, word_two,
                 word_three, final_item, output ready);
endinterface

interface dspiv_rsp_if import dspiv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               image_ok;
   logic [BYTES_W-1:0] required_bytes;

   modport source (output valid, image_ok, required_bytes, input ready);
   modport sink (input valid, image_ok, required_bytes, output ready);
endinterface

@@ rtl/dspiv_ram.sv @@
module dspiv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/dspiv_step_check.sv @@
module dspiv_step_check import dspiv_pkg::*; (
   input  req_beat_type      beat,
   input  logic [WORD_W-1:0] table_data,
   input  logic              table_valid,
   output chk_result_type    result
);
   logic [5:0]        in_addr;
   logic              has_ctl;
   logic              step_fail;
   logic [WORD_W-1:0] first;
   logic [WORD_W-1:0] first_adj;
   logic [WORD_W-1:0] last;
   logic [WORD_W:0]   last_p1;

   always_comb begin
      in_addr = beat.word_one[12:7];
      has_ctl = ((beat.word_two & (MEM_TABLE | MEM_WRITE | MEM_READ)) != '0) ||
                ((beat.word_three & (CTL_NO_FLOAT | CTL_INDEX_MASK | CTL_ADDR_REG |
                                     CTL_NEXT)) != '0);
      step_fail = beat.word_zero[0] || beat.word_one[0] ||
                  ((beat.word_three & CTL_RESERVED) != '0) || (in_addr > LAST_INPUT) ||
                  (has_ctl && !beat.index[0]);

      // entries never written since the last image read as zero
      first     = table_valid ? table_data : '0;
      first_adj = ((beat.word_three & CTL_NEXT) != '0) ? first + 16'd1 : first;
      if ((beat.word_three & CTL_ADDR_REG) != '0) begin
         last = (first_adj > SPAN_LIMIT) ? WORD_ADDR_MAX : first_adj + ADDR_REG_SPAN;
      end else begin
         last = first_adj;
      end
      last_p1 = {1'b0, last} + 17'd1;

      result = '0;
      result.bytes = {last_p1, 1'b0};
      case (cmd_type'(beat.command))
         CMD_COEF: begin
            result.fail = (beat.word_zero & COEF_RESERVED) != '0;
         end
         CMD_STEP: begin
            if ({1'b0, beat.index} < STEP_COUNT) begin
               result.nonzero = (beat.word_zero | beat.word_one | beat.word_two |
                                 beat.word_three) != '0;
               result.fail    = step_fail;
               result.access  = ((beat.word_two & MEM_TABLE) != '0) &&
                                ((beat.word_two & (MEM_READ | MEM_WRITE)) != '0);
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end
endmodule

@@ rtl/dsp_image_validator_unit.sv @@
// Image checker for a sound-DSP program. Takes one beat per cycle (coefficient
// word, address-table entry or four-word step) and keeps no bubble between
// beats; req ready drops only while a result sits unclaimed in the output
// register and the next beat in the check stage is itself a final beat. A
// result reaches the output register once the check stage advances its final
// beat: the 64 x 16 address-table RAM is read on the accepting edge together
// with the input register, and the step checks and the byte-need maximum settle
// in the cycle that follows. The address table is cleared at reset and whenever
// a final beat is accepted, through per-entry valid bits, so there is no clearing
// pass. Ring size and initial byte registers are written through the csr port;
// the user must do so only while no image is in flight; the block does not check.
module dsp_image_validator_unit import dspiv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   dspiv_req_if.sink              req_chan,
   dspiv_rsp_if.source            rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);
   logic [1:0]           ring_code_ff, ring_code_in;
   logic [BYTES_W-1:0]   init_bytes_ff, init_bytes_in;

   logic [ADDRESS_ENTRIES-1:0] entry_vld_ff, entry_vld_in;
   logic                       tbl_vld_ff, tbl_vld_in;
   logic [WORD_W-1:0]          tbl_data;

   logic                 s1_vld_ff, s1_vld_in;
   req_beat_type         s1_beat_ff, s1_beat_in;
   logic                 s1_adv;

   logic                 fail_ff, fail_in;
   logic                 nonzero_ff, nonzero_in;
   logic [BYTES_W-1:0]   need_max_ff, need_max_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   req_beat_type         in_beat;
   logic                 accept;
   logic                 tbl_wr;
   chk_result_type       chk;
   logic                 fail_all;
   logic                 nonzero_all;
   logic [BYTES_W-1:0]   need_all;
   logic [BYTES_W-1:0]   ring_need;
   logic [BYTES_W-1:0]   need;

   always_comb begin
      in_beat.command    = req_chan.command;
      in_beat.index      = req_chan.index;
      in_beat.word_zero  = req_chan.word_zero;
      in_beat.word_one   = req_chan.word_one;
      in_beat.word_two   = req_chan.word_two;
      in_beat.word_three = req_chan.word_three;
      in_beat.final_item = req_chan.final_item;
   end

   assign s1_adv         = s1_vld_ff && (!s1_beat_ff.final_item || !rsp_vld_ff ||
                                         rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign tbl_wr         = accept && (cmd_type'(in_beat.command) == CMD_ADDR) &&
                           !in_beat.index[INDEX_W-1];

   // table read and write both happen on the accepting edge, so beats never race
   dspiv_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ADDRESS_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_wr),
      .wr_addr(in_beat.index[ADDR_IDX_W-1:0]),
      .wr_data(in_beat.word_zero),
      .rd_en  (accept),
      .rd_addr(in_beat.word_three[14:9]),
      .rd_data(tbl_data)
   );

   dspiv_step_check u_check (
      .beat       (s1_beat_ff),
      .table_data (tbl_data),
      .table_valid(tbl_vld_ff),
      .result     (chk)
   );

   always_comb begin
      ring_code_in  = ring_code_ff;
      init_bytes_in = init_bytes_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RING_SIZE:  ring_code_in  = csr_data[1:0];
            CSR_INIT_BYTES: init_bytes_in = csr_data[BYTES_W-1:0];
            default: begin
               ring_code_in = ring_code_ff;
            end
         endcase
      end

      entry_vld_in = entry_vld_ff;
      tbl_vld_in   = tbl_vld_ff;
      s1_vld_in    = s1_vld_ff;
      s1_beat_in   = s1_beat_ff;
      if (accept) begin
         tbl_vld_in = entry_vld_ff[in_beat.word_three[14:9]];
         s1_beat_in = in_beat;
         if (tbl_wr) begin
            entry_vld_in[in_beat.index[ADDR_IDX_W-1:0]] = 1'b1;
         end
         if (in_beat.final_item) begin
            entry_vld_in = '0;
         end
      end
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end

      fail_all    = fail_ff || chk.fail;
      nonzero_all = nonzero_ff || chk.nonzero;
      need_all    = (chk.access && (chk.bytes > need_max_ff)) ? chk.bytes : need_max_ff;
      ring_need   = RING_BASE << ring_code_ff;
      need        = (init_bytes_ff > ring_need) ? init_bytes_ff : ring_need;
      need        = (need_all > need) ? need_all : need;

      fail_in     = fail_ff;
      nonzero_in  = nonzero_ff;
      need_max_in = need_max_ff;
      if (s1_adv) begin
         if (s1_beat_ff.final_item) begin
            fail_in     = 1'b0;
            nonzero_in  = 1'b0;
            need_max_in = '0;
         end else begin
            fail_in     = fail_all;
            nonzero_in  = nonzero_all;
            need_max_in = need_all;
         end
      end

      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_bytes_in = rsp_bytes_ff;
      if (s1_adv && s1_beat_ff.final_item) begin
         rsp_vld_in   = 1'b1;
         rsp_ok_in    = !fail_all && nonzero_all && (init_bytes_ff <= MAX_WORK_BYTES) &&
                        (need <= MAX_WORK_BYTES);
         rsp_bytes_in = rsp_ok_in ? need : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_code_ff  <= '0;
         init_bytes_ff <= '0;
         entry_vld_ff  <= '0;
         s1_vld_ff     <= 1'b0;
         fail_ff       <= 1'b0;
         nonzero_ff    <= 1'b0;
         need_max_ff   <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         ring_code_ff  <= ring_code_in;
         init_bytes_ff <= init_bytes_in;
         entry_vld_ff  <= entry_vld_in;
         s1_vld_ff     <= s1_vld_in;
         fail_ff       <= fail_in;
         nonzero_ff    <= nonzero_in;
         need_max_ff   <= need_max_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_vld_ff   <= tbl_vld_in;
      s1_beat_ff   <= s1_beat_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.image_ok       = rsp_ok_ff;
   assign rsp_chan.required_bytes = rsp_bytes_ff;
endmodule

@@ rtl/dspiv_checker.sv @@
`include "dsp_image_validator_unit_defines.svh"

module dspiv_checker import dspiv_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               image_ok,
   input logic [BYTES_W-1:0] required_bytes
);
   logic             fail_beat;
   logic             ok_beat;
   logic             stall_beat;
   logic             bytes_in_range;
   logic [BYTES_W:0] rsp_payload;

   assign fail_beat      = rsp_valid && !image_ok;
   assign ok_beat        = rsp_valid && image_ok;
   assign stall_beat     = rsp_valid && !rsp_ready;
   assign bytes_in_range = (required_bytes >= RING_BASE) && (required_bytes <= MAX_WORK_BYTES);
   assign rsp_payload    = {image_ok, required_bytes};

   // a failed image never reports a byte count
   `DSPIV_ASSERT_IMPLY(a_fail_zero, clock, reset, fail_beat, required_bytes == '0)

   // a passing image needs at least the smallest ring and stays within the limit
   `DSPIV_ASSERT_IMPLY(a_ok_range, clock, reset, ok_beat, bytes_in_range)

   // nothing is reported right after reset
   `DSPIV_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   `DSPIV_ASSERT_NEXT(a_rsp_hold, clock, reset, stall_beat, rsp_valid && $stable(rsp_payload))
endmodule

bind dsp_image_validator_unit dspiv_checker u_dspiv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .image_ok      (rsp_chan.image_ok),
   .required_bytes(rsp_chan.required_bytes)
);

@@ bench/dsp_image_validator_unit_test.sv @@
`timescale 1ns / 100ps

module dsp_image_validator_unit_test;
   import dspiv_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
   localparam int         RSP_HOLD_CYCLES = 120;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         RANDOM_BEATS    = 600;
   localparam int         PHASE_COUNT     = 8;
   localparam int         TIMEOUT_NS      = 2_000_000;

   typedef struct {
      logic               image_ok;
      logic [BYTES_W-1:0] required_bytes;
   } verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   dspiv_req_if req_chan ();
   dspiv_rsp_if rsp_chan ();

   dsp_image_validator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the registers and of the image state
   logic [1:0]         ring_code_cfg  = '0;
   logic [BYTES_W-1:0] init_bytes_cfg = '0;
   logic [WORD_W-1:0]  table_words [ADDRESS_ENTRIES] = '{default: '0};
   int unsigned        need_peak      = 0;
   bit                 image_failed   = 1'b0;
   bit                 saw_nonzero    = 1'b0;

   req_beat_type image_beats_pending [$];
   verdict_type  verdicts_due [$];
   req_beat_type beat_on_bus;
   int           mismatch_count = 0;

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int req_gap_left;
   int rsp_gap_left;
   int rsp_hold_left;
   int rsp_holds_asked = 0;
   int rsp_holds_done  = 0;

   // mostly no gap, some short, a few long
   function automatic int idle_stretch();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic req_beat_type make_beat(logic [1:0] cmd, logic [INDEX_W-1:0] idx,
                                              logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                              logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3,
                                              logic last);
      req_beat_type b;
      b.command    = cmd;
      b.index      = idx;
      b.word_zero  = w0;
      b.word_one   = w1;
      b.word_two   = w2;
      b.word_three = w3;
      b.final_item = last;
      return b;
   endfunction

   // applies one accepted beat to the image state, queues a verdict on the final beat
   function automatic void score_image_beat(req_beat_type b);
      bit          has_ctl;
      int unsigned first_word;
      int unsigned last_word;
      int unsigned bytes;
      int unsigned need;
      bit          ok;
      verdict_type v;
      case (b.command)
         CMD_COEF: begin
            if ((b.word_zero & COEF_RESERVED) != '0)
               image_failed = 1'b1;
         end
         CMD_ADDR: begin
            if (b.index < ADDRESS_ENTRIES)
               table_words[b.index[ADDR_IDX_W-1:0]] = b.word_zero;
         end
         CMD_STEP: begin
            if ({1'b0, b.index} < STEP_COUNT) begin
               has_ctl = (b.word_two & (MEM_TABLE | MEM_WRITE | MEM_READ)) != '0 ||
                  (b.word_three & (CTL_NO_FLOAT | CTL_INDEX_MASK | CTL_ADDR_REG | CTL_NEXT)) != '0;
               if ((b.word_zero | b.word_one | b.word_two | b.word_three) != '0)
                  saw_nonzero = 1'b1;
               if (b.word_zero[0] || b.word_one[0] || (b.word_three & CTL_RESERVED) != '0 ||
                   b.word_one[12:7] > LAST_INPUT)
                  image_failed = 1'b1;
               if (has_ctl && !b.index[0])
                  image_failed = 1'b1;
               if ((b.word_two & (MEM_READ | MEM_WRITE)) != '0 &&
                   (b.word_two & MEM_TABLE) != '0) begin
                  first_word = 32'(table_words[b.word_three[14:9]]);
                  if ((b.word_three & CTL_NEXT) != '0)
                     first_word = (first_word + 1) & 32'(WORD_ADDR_MAX);
                  if ((b.word_three & CTL_ADDR_REG) != '0)
                     last_word = (first_word > 32'(WORD_ADDR_MAX - ADDR_REG_SPAN)) ?
                        32'(WORD_ADDR_MAX) : first_word + 32'(ADDR_REG_SPAN);
                  else
                     last_word = first_word;
                  bytes = (last_word + 1) * 2;
                  if (bytes > need_peak)
                     need_peak = bytes;
               end
            end
         end
         default: ;
      endcase
      if (b.final_item) begin
         need = 32'(RING_BASE) << ring_code_cfg;
         if (init_bytes_cfg > need)
            need = 32'(init_bytes_cfg);
         if (need_peak > need)
            need = need_peak;
         ok = !image_failed && saw_nonzero && init_bytes_cfg <= MAX_WORK_BYTES &&
              need <= MAX_WORK_BYTES;
         v.image_ok       = ok;
         v.required_bytes = ok ? need[BYTES_W-1:0] : '0;
         verdicts_due.push_back(v);
         foreach (table_words[i])
            table_words[i] = '0;
         need_peak    = 0;
         image_failed = 1'b0;
         saw_nonzero  = 1'b0;
      end
   endfunction

   function automatic req_beat_type wellformed_beat();
      req_beat_type b;
      int unsigned  pick;
      b = '0;
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
         b.command   = CMD_COEF;
         b.index     = INDEX_W'($urandom);
         b.word_zero = WORD_W'($urandom & ~COEF_RESERVED);
      end else if (pick < 4) begin
         b.command = CMD_ADDR;
         b.index   = INDEX_W'($urandom_range(0, ADDRESS_ENTRIES - 1));
         // bias addresses toward the wrap and saturation edges
         case ($urandom_range(0, 3))
            0:       b.word_zero = WORD_W'(WORD_ADDR_MAX - $urandom_range(0, 3));
            1:       b.word_zero = WORD_W'(SPAN_LIMIT + $urandom_range(0, 2) - 1);
            2:       b.word_zero = WORD_W'($urandom_range(0, 255));
            default: b.word_zero = WORD_W'($urandom);
         endcase
      end else begin
         b.command   = CMD_STEP;
         b.index     = INDEX_W'($urandom);
         b.word_zero = WORD_W'($urandom & ~16'h0001);
         b.word_one  = WORD_W'(($urandom & ~(IN_ADDR_MASK | 16'h0001)) |
                               (16'($urandom_range(0, LAST_INPUT)) << 7));
         if (b.index[0]) begin
            b.word_two     = WORD_W'($urandom);
            b.word_two[15] = $urandom_range(0, 3) != 0;
            b.word_three   = WORD_W'($urandom & ~CTL_RESERVED);
         end else begin
            b.word_two = WORD_W'($urandom & ~(MEM_TABLE | MEM_WRITE | MEM_READ));
         end
      end
      return b;
   endfunction

   function automatic req_beat_type spoil_beat(req_beat_type b);
      int unsigned fault;
      fault = $urandom_range(0, 5);
      if (fault == 0) begin
         b.command = CMD_COEF;
         b.word_zero[$urandom_range(0, 2)] = 1'b1;
      end else begin
         b.command = CMD_STEP;
         case (fault)
            1: b.word_zero[0] = 1'b1;
            2: b.word_one[0] = 1'b1;
            3: b.word_three[$urandom_range(0, 6)] = 1'b1;
            4: b.word_one[12:7] = 6'($urandom_range(LAST_INPUT + 1, 63));
            default: begin
               // memory control on an even step
               b.index[0] = 1'b0;
               b.word_two[$urandom_range(13, 15)] = 1'b1;
            end
         endcase
      end
      return b;
   endfunction

   task automatic queue_random_image(int n_beats);
      int unsigned  kind;
      int           fault_at;
      req_beat_type b;
      kind     = $urandom_range(0, 9);
      fault_at = $urandom_range(0, n_beats - 1);
      for (int i = 0; i < n_beats; i++) begin
         if (kind == 9) begin
            b.command    = 2'($urandom_range(0, 3));
            b.index      = INDEX_W'($urandom);
            b.word_zero  = WORD_W'($urandom);
            b.word_one   = WORD_W'($urandom);
            b.word_two   = WORD_W'($urandom);
            b.word_three = WORD_W'($urandom);
         end else begin
            b = wellformed_beat();
            if (kind >= 7 && i == fault_at)
               b = spoil_beat(b);
         end
         b.final_item = (i == n_beats - 1);
         image_beats_pending.push_back(b);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RING_SIZE)
         ring_code_cfg = data[1:0];
      else
         init_bytes_cfg = data;
   endtask

   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (image_beats_pending.size() != 0 || req_chan.valid || verdicts_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            score_image_beat(beat_on_bus);
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap_left == 0 && req_idle_on)
               req_gap_left = idle_stretch();
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_chan.valid <= 1'b0;
            end else if (image_beats_pending.size() != 0) begin
               beat_on_bus = image_beats_pending.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.command    <= beat_on_bus.command;
               req_chan.index      <= beat_on_bus.index;
               req_chan.word_zero  <= beat_on_bus.word_zero;
               req_chan.word_one   <= beat_on_bus.word_one;
               req_chan.word_two   <= beat_on_bus.word_two;
               req_chan.word_three <= beat_on_bus.word_three;
               req_chan.final_item <= beat_on_bus.final_item;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap_left  = 0;
         rsp_hold_left = 0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_holds_done != rsp_holds_asked) begin
         // long hold-off so finished images back up into the input
         rsp_holds_done++;
         rsp_hold_left = RSP_HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_gap_left == 0 && rsp_idle_on)
            rsp_gap_left = idle_stretch();
         if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin : result_monitor
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdicts_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: image_ok %0b required_bytes %0d",
                        rsp_chan.image_ok, rsp_chan.required_bytes);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_chan.image_ok !== want.image_ok ||
                rsp_chan.required_bytes !== want.required_bytes) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected ok %0b bytes %0d, got ok %0b bytes %0d",
                           want.image_ok, want.required_bytes,
                           rsp_chan.image_ok, rsp_chan.required_bytes);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]         ring_pick;
      logic [BYTES_W-1:0] bytes_pick;
      int                 phase_beats;
      int                 n;

      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_COEF;
      req_chan.index      = '0;
      req_chan.word_zero  = '0;
      req_chan.word_one   = '0;
      req_chan.word_two   = '0;
      req_chan.word_three = '0;
      req_chan.final_item = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_RING_SIZE;
      csr_data            = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      // only zero words: no nonzero step seen
      image_beats_pending.push_back(make_beat(CMD_COEF, 7'd0, 16'h0000, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd1, '0, '0, '0, '0, 1'b1));
      // table edges: wrap on next address, saturation and the exact top
      image_beats_pending.push_back(make_beat(CMD_ADDR, 7'd0, WORD_ADDR_MAX, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_ADDR, 7'd63, 16'hf001, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_ADDR, 7'd62, 16'hefff, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_ADDR, 7'd64, 16'h1000, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_COEF, 7'd0, ~COEF_RESERVED, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd1, 16'hfffe, 16'hf8fe, 16'hffff,
                                              CTL_NEXT, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd3, '0, '0, MEM_TABLE | MEM_WRITE,
                                              CTL_ADDR_REG | 16'(63 << 9), 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd5, '0, '0, MEM_TABLE | MEM_READ,
                                              CTL_NO_FLOAT | CTL_ADDR_REG | 16'(62 << 9), 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd126, '0, '0, 16'h1fff, '0, 1'b1));
      // out-of-range entry must not alias, and the table must be clear again
      image_beats_pending.push_back(make_beat(CMD_ADDR, 7'd64, WORD_ADDR_MAX, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd1, '0, '0, MEM_TABLE | MEM_READ,
                                              '0, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_COEF, 7'd0, 16'h0004, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd1, 16'h0002, '0, '0, '0, 1'b1));
      // unknown command still closes the image
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd5, 16'h0002, '0, '0, '0, 1'b0));
      image_beats_pending.push_back(make_beat(CMD_UNKNOWN, 7'd127, 16'hffff, 16'hffff,
                                              16'hffff, 16'hffff, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd0, 16'h0002, '0, '0,
                                              CTL_NO_FLOAT, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd7, '0, 16'(50 << 7), '0, '0, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd9, '0, '0, '0, CTL_RESERVED, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd11, 16'h0001, '0, '0, '0, 1'b1));
      image_beats_pending.push_back(make_beat(CMD_STEP, 7'd13, '0, 16'h0001, '0, '0, 1'b1));
      wait_until_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin ring_pick = 2'd3; bytes_pick = '0; end
            1: begin ring_pick = 2'd0; bytes_pick = '1; end
            2: begin ring_pick = 2'd2; bytes_pick = MAX_WORK_BYTES; end
            3: begin ring_pick = 2'd1; bytes_pick = BYTES_W'(MAX_WORK_BYTES + 1); end
            default: begin
               ring_pick = 2'($urandom_range(0, 3));
               case ($urandom_range(0, 3))
                  0:       bytes_pick = '0;
                  3:       bytes_pick = BYTES_W'($urandom);
                  default: bytes_pick = BYTES_W'($urandom_range(0, MAX_WORK_BYTES));
               endcase
            end
         endcase
         write_csr(CSR_RING_SIZE, CSR_DATA_W'(ring_pick));
         write_csr(CSR_INIT_BYTES, bytes_pick);

         if (phase == 0) begin
            req_idle_on = 1'b1;
            rsp_idle_on = 1'b1;
         end else if (phase == 1 || phase == 2) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on = $urandom_range(0, 3) != 0;
         end
         if (phase == 2)
            rsp_holds_asked++;

         phase_beats = 0;
         while (phase_beats < RANDOM_BEATS / PHASE_COUNT) begin
            n = (phase == 2) ? $urandom_range(1, 3) : $urandom_range(1, 24);
            queue_random_image(n);
            phase_beats += n;
         end
         wait_until_drained();
      end

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
